// File: hdl/tbts_pkg.sv
package tbts_pkg;

    // Default number of task slots.
    localparam int NUM_SLOTS_DEF = 16;

    // Width of a priority and of a tick budget.
    localparam int BUDGET_W = 8;

    // Event codes carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SLEEP = 2'd1;
    localparam logic [1:0] MODE_WAKE  = 2'd2;
    localparam logic [1:0] MODE_LOAD  = 2'd3;

    // One command beat.
    typedef struct packed {
        logic [1:0]          mode;
        logic [3:0]          task_index;
        logic [BUDGET_W-1:0] priority_req;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [3:0]  current_task;
        logic        switched;
        logic        accepted;
        logic [31:0] elapsed_ticks;
    } result_t;

endpackage

// File: hdl/tbts_ram.sv
module tbts_ram #(
    parameter int WIDTH = tbts_pkg::BUDGET_W,
    parameter int DEPTH = tbts_pkg::NUM_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/tick_budget_task_scheduler_unit.sv
// Tick-budget task scheduler. A command beat is taken when start is high and
// busy is low; exactly one result beat follows, shown for one cycle with done
// high, and the receiver must take it then. The work is done by a small
// sequencer that walks the slot table one slot a cycle through the budget
// or priority memory read port and a single shared budget comparator. Busy
// stays high while an event runs: a timer tick first takes one off the
// running task's nonzero budget, and when the walk finds no budget left the
// priorities are copied back into the budgets in a second walk; done is
// high in the first cycle with busy low. An ignored sleep, wake or load
// skips the walk.
module tick_budget_task_scheduler_unit #(
    parameter int NUM_SLOTS = tbts_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tbts_pkg::cmd_t    cmd,
    output logic              done,
    output tbts_pkg::result_t result
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int BW = tbts_pkg::BUDGET_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_TICK_WR = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DECIDE  = 3'd4;
    localparam logic [2:0] S_FILL    = 3'd5;
    localparam logic [2:0] S_FINISH  = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    tbts_pkg::cmd_t        cmd_reg;
    logic [NUM_SLOTS-1:0]  present_reg;
    logic [NUM_SLOTS-1:0]  running_reg;
    logic [NUM_SLOTS-1:0]  loaded_reg;
    logic [IW-1:0]         running_slot_reg;
    logic [31:0]           tick_total_reg;
    logic                  iss_on_reg;
    logic [IW-1:0]         iss_k_reg;
    logic                  cmp_on_reg;
    logic [IW-1:0]         cmp_k_reg;
    logic [IW-1:0]         best_reg;
    logic [BW-1:0]         best_bud_reg;
    logic                  ok_reg;
    logic                  done_reg;
    tbts_pkg::result_t     result_reg;

    logic [IW-1:0]         cmd_slot;
    logic                  cmd_valid;
    logic                  exec_ok;
    logic                  scan_init;
    logic                  scan_end;
    logic                  bud_we;
    logic [IW-1:0]         bud_waddr;
    logic [BW-1:0]         bud_wdata;
    logic                  bud_re;
    logic [IW-1:0]         bud_raddr;
    logic [BW-1:0]         bud_rdata;
    logic                  pri_we;
    logic                  pri_re;
    logic [BW-1:0]         pri_rdata;
    logic [IW-1:0]         gate_idx;
    logic [BW-1:0]         bud_val;
    logic [BW-1:0]         pri_val;
    logic                  take;

    // Addressed slot and whether it exists.
    assign cmd_slot  = IW'(cmd_reg.task_index);
    assign cmd_valid = ({28'd0, cmd_reg.task_index} < 32'(NUM_SLOTS));

    // Whether the addressed event is legal.
    always_comb
    begin
        unique case (cmd_reg.mode)
            tbts_pkg::MODE_TICK:  exec_ok = 1'b1;
            tbts_pkg::MODE_SLEEP: exec_ok = cmd_valid && present_reg[cmd_slot]
                                            && running_reg[cmd_slot];
            tbts_pkg::MODE_WAKE:  exec_ok = cmd_valid && present_reg[cmd_slot]
                                            && !running_reg[cmd_slot];
            tbts_pkg::MODE_LOAD:  exec_ok = cmd_valid;
            default:              exec_ok = 1'b0;
        endcase
    end

    // Memory entries never loaded read as zero.
    assign gate_idx = (state_reg == S_TICK_WR) ? running_slot_reg : cmp_k_reg;
    assign bud_val  = loaded_reg[gate_idx] ? bud_rdata : '0;
    assign pri_val  = loaded_reg[cmp_k_reg] ? pri_rdata : '0;

    // Shared budget comparator: slot 0 is the starting candidate.
    assign take = (cmp_k_reg == '0)
                  || (present_reg[cmp_k_reg] && running_reg[cmp_k_reg]
                      && (bud_val >= best_bud_reg));

    assign scan_end = cmp_on_reg && (cmp_k_reg == LAST_SLOT);

    // Sequencer and memory port control.
    always_comb
    begin
        state_next = state_reg;
        scan_init  = 1'b0;
        bud_we     = 1'b0;
        bud_waddr  = cmd_slot;
        bud_wdata  = cmd_reg.priority_req;
        bud_re     = 1'b0;
        bud_raddr  = iss_k_reg;
        pri_we     = 1'b0;
        pri_re     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg.mode == tbts_pkg::MODE_TICK)
                begin
                    bud_re     = 1'b1;
                    bud_raddr  = running_slot_reg;
                    state_next = S_TICK_WR;
                end
                else if (exec_ok)
                begin
                    if (cmd_reg.mode == tbts_pkg::MODE_LOAD)
                    begin
                        bud_we = 1'b1;
                        pri_we = 1'b1;
                    end
                    scan_init  = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_TICK_WR:
            begin
                bud_waddr  = running_slot_reg;
                bud_wdata  = bud_val - BW'(1);
                bud_we     = (bud_val != '0);
                scan_init  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                bud_re = iss_on_reg;
                if (scan_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (best_bud_reg == '0)
                begin
                    scan_init  = 1'b1;
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FILL:
            begin
                pri_re    = iss_on_reg;
                bud_we    = cmp_on_reg && present_reg[cmp_k_reg];
                bud_waddr = cmp_k_reg;
                bud_wdata = pri_val;
                if (scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            present_reg      <= {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            running_reg      <= {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            loaded_reg       <= '0;
            running_slot_reg <= '0;
            tick_total_reg   <= '0;
            iss_on_reg       <= 1'b0;
            iss_k_reg        <= '0;
            cmp_on_reg       <= 1'b0;
            cmp_k_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);

            // Slot walk: one read issued and one compared or written back each cycle.
            if (scan_init)
            begin
                iss_on_reg <= 1'b1;
                iss_k_reg  <= '0;
                cmp_on_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN || state_reg == S_FILL)
            begin
                cmp_on_reg <= iss_on_reg;
                cmp_k_reg  <= iss_k_reg;
                if (iss_on_reg)
                begin
                    if (iss_k_reg == LAST_SLOT)
                    begin
                        iss_on_reg <= 1'b0;
                    end
                    else
                    begin
                        iss_k_reg <= iss_k_reg + IW'(1);
                    end
                end
            end

            // Event bookkeeping on the slot bits.
            if (state_reg == S_EXEC && exec_ok)
            begin
                unique case (cmd_reg.mode)
                    tbts_pkg::MODE_SLEEP: running_reg[cmd_slot] <= 1'b0;
                    tbts_pkg::MODE_WAKE:  running_reg[cmd_slot] <= 1'b1;
                    tbts_pkg::MODE_LOAD:
                    begin
                        present_reg[cmd_slot] <= 1'b1;
                        running_reg[cmd_slot] <= 1'b1;
                        loaded_reg[cmd_slot]  <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_TICK_WR)
            begin
                tick_total_reg <= tick_total_reg + 32'd1;
            end

            // Switch to the winner.
            if (state_reg == S_FINISH && best_reg != running_slot_reg)
            begin
                running_slot_reg      <= best_reg;
                running_reg[best_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_EXEC)
        begin
            ok_reg   <= exec_ok;
            best_reg <= running_slot_reg;
        end
        if (state_reg == S_SCAN && cmp_on_reg && take)
        begin
            best_reg     <= cmp_k_reg;
            best_bud_reg <= bud_val;
        end
        if (state_reg == S_DECIDE && best_bud_reg == '0)
        begin
            best_reg <= '0;
        end
        if (state_reg == S_FINISH)
        begin
            result_reg.current_task  <= 4'(best_reg);
            result_reg.switched      <= (best_reg != running_slot_reg);
            result_reg.accepted      <= ok_reg;
            result_reg.elapsed_ticks <= tick_total_reg;
        end
    end

    // Budget and priority tables.
    tbts_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_SLOTS)
    ) u_budget_ram (
        .clk   (clk),
        .we    (bud_we),
        .waddr (bud_waddr),
        .wdata (bud_wdata),
        .re    (bud_re),
        .raddr (bud_raddr),
        .rdata (bud_rdata)
    );

    tbts_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_SLOTS)
    ) u_priority_ram (
        .clk   (clk),
        .we    (pri_we),
        .waddr (cmd_slot),
        .wdata (cmd_reg.priority_req),
        .re    (pri_re),
        .raddr (iss_k_reg),
        .rdata (pri_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat only follows the closing step of an event.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FINISH))
        else $error("result beat without a finished event");

    // A taken command always makes the block busy.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // An ignored event never changes the current task.
    a_switch_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.switched) |-> result.accepted)
        else $error("task switch on an ignored event");

    // The current task always sits in a present slot.
    a_current_present: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg[running_slot_reg])
        else $error("current task slot not present");

    // A finished walk never leaves a read still pending.
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && state_next == S_DECIDE) |-> !iss_on_reg)
        else $error("slot walk ended with reads still pending");

endmodule
